### src/core_switch_collective_router_unit_defines.svh
// assertion macros shared by the collective router modules
// needs clk and rst in the scope of each use
`ifndef CORE_SWITCH_COLLECTIVE_ROUTER_UNIT_DEFINES_SVH
`define CORE_SWITCH_COLLECTIVE_ROUTER_UNIT_DEFINES_SVH

// same-cycle implication
`define CSR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/csr_pkg.sv
// types, codes and constants of the collective router
// used by every module of the block
`default_nettype none

package csr_pkg;

  localparam int PORTS_DEF      = 4;
  localparam int NODES_DEF      = 16;
  localparam int NODES_PER_PORT = 4;

  localparam int TYPE_W = 3;
  localparam int PORT_W = 2;
  localparam int NODE_W = 4;
  localparam int OP_W   = 2;
  localparam int DATA_W = 32;
  localparam int KIND_W = 3;
  localparam int STAT_W = 3;

  localparam logic [TYPE_W-1:0] REQ_UNICAST   = 3'd0;
  localparam logic [TYPE_W-1:0] REQ_BROADCAST = 3'd1;
  localparam logic [TYPE_W-1:0] REQ_BARRIER   = 3'd2;
  localparam logic [TYPE_W-1:0] REQ_REDUCE    = 3'd3;

  localparam logic [OP_W-1:0] OP_MAX = 2'd0;
  localparam logic [OP_W-1:0] OP_MIN = 2'd1;
  localparam logic [OP_W-1:0] OP_SUM = 2'd2;
  localparam logic [OP_W-1:0] OP_MUL = 2'd3;

  localparam logic [KIND_W-1:0] KIND_NONE    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_UNICAST = 3'd1;
  localparam logic [KIND_W-1:0] KIND_BCAST   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_REDUCE  = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK          = 3'd0;
  localparam logic [STAT_W-1:0] ST_DUP_BARRIER = 3'd1;
  localparam logic [STAT_W-1:0] ST_SAME_PORT   = 3'd2;
  localparam logic [STAT_W-1:0] ST_DUP_REDUCE  = 3'd3;
  localparam logic [STAT_W-1:0] ST_OP_MISMATCH = 3'd4;
  localparam logic [STAT_W-1:0] ST_TARGET_SRC  = 3'd5;
  localparam logic [STAT_W-1:0] ST_UNKNOWN     = 3'd6;

  typedef struct packed {
    logic [TYPE_W-1:0]        req_type;
    logic [PORT_W-1:0]        source_port;
    logic [NODE_W-1:0]        dest_node;
    logic [NODE_W-1:0]        source_node;
    logic [OP_W-1:0]          op_type;
    logic signed [DATA_W-1:0] data;
  } msg_t;

  typedef struct packed {
    logic [PORT_W-1:0]        out_port;
    logic [KIND_W-1:0]        out_kind;
    logic [NODE_W-1:0]        out_dest;
    logic [OP_W-1:0]          out_op;
    logic signed [DATA_W-1:0] out_data;
    logic [STAT_W-1:0]        status;
    logic                     last;
  } res_t;

  typedef enum logic [1:0] {
    FAN_ONE,
    FAN_BCAST,
    FAN_ALL
  } fan_t;

  typedef struct packed {
    fan_t                     fan;
    logic [PORT_W-1:0]        sp;
    logic [PORT_W-1:0]        port;
    logic [KIND_W-1:0]        kind;
    logic [NODE_W-1:0]        dest;
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] data;
    logic [STAT_W-1:0]        status;
  } job_t;

endpackage

`default_nettype wire

### src/csr_engine.sv
// input register, routing decision and barrier / reduce state
// depends on csr_pkg and the assertion macro header
`default_nettype none

`include "core_switch_collective_router_unit_defines.svh"

module csr_engine import csr_pkg::*; #(
  parameter int PORTS = PORTS_DEF,
  parameter int NODES = NODES_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic msg_valid,
  output logic      msg_stall,
  input  wire msg_t msg,
  input  wire logic job_ready,
  output logic      job_load,
  output job_t      job_n
);

  localparam int BF_DEPTH = (NODES < 16) ? NODES : 16;
  localparam int BFW      = $clog2(BF_DEPTH);
  localparam int BCW      = $clog2(BF_DEPTH + 1);
  localparam int RF_DEPTH = (PORTS < 4) ? PORTS : 4;
  localparam int RFW      = $clog2(RF_DEPTH);
  localparam int RCW      = $clog2(RF_DEPTH + 1);

  logic                     in_valid;
  msg_t                     in_q;

  logic [BF_DEPTH-1:0]      bflags, bflags_next;
  logic [BCW-1:0]           bcount, bcount_next, bcount_inc;
  logic [RF_DEPTH-1:0]      rflags, rflags_next, nf;
  logic [RCW-1:0]           rcount, rcount_next, rcount_inc;
  logic [NODE_W-1:0]        rdest, rdest_next, nd;
  logic [OP_W-1:0]          rop, rop_next, no;
  logic signed [DATA_W-1:0] rval, rval_next, nv, folded, prod;

  logic                     quiet, proceed, sp_ok, any;
  logic [RFW-1:0]           sp_i;
  logic [BFW-1:0]           sn_i;
  logic [PORT_W-1:0]        tp, tp2;

  assign sp_ok      = 32'(in_q.source_port) < PORTS;
  assign sp_i       = in_q.source_port[RFW-1:0];
  assign sn_i       = in_q.source_node[BFW-1:0];
  assign tp         = PORT_W'(in_q.dest_node / NODES_PER_PORT);
  assign bcount_inc = bcount + BCW'(1);
  assign rcount_inc = rcount + RCW'(1);
  assign any        = |rflags;
  assign prod       = rval * in_q.data;

  always_comb begin
    case (rop)
      OP_MAX:  folded = (in_q.data > rval) ? in_q.data : rval;
      OP_MIN:  folded = (in_q.data < rval) ? in_q.data : rval;
      OP_SUM:  folded = rval + in_q.data;
      OP_MUL:  folded = prod;
      default: folded = rval;
    endcase
  end

  assign nd  = any ? rdest : in_q.dest_node;
  assign no  = any ? rop : in_q.op_type;
  assign nv  = any ? folded : in_q.data;
  assign tp2 = PORT_W'(nd / NODES_PER_PORT);

  always_comb begin
    nf       = rflags;
    nf[sp_i] = 1'b1;
  end

  always_comb begin
    job_n        = '0;
    job_n.fan    = FAN_ONE;
    job_n.sp     = in_q.source_port;
    quiet        = 1'b0;
    bflags_next  = bflags;
    bcount_next  = bcount;
    rflags_next  = rflags;
    rcount_next  = rcount;
    rdest_next   = rdest;
    rop_next     = rop;
    rval_next    = rval;
    if (!sp_ok) begin
      job_n.status = ST_UNKNOWN;
    end else begin
      case (in_q.req_type)
        REQ_UNICAST: begin
          if (32'(tp) >= PORTS) begin
            job_n.status = ST_UNKNOWN;
          end else begin
            job_n.port   = tp;
            job_n.kind   = KIND_UNICAST;
            job_n.dest   = in_q.dest_node;
            job_n.data   = in_q.data;
            job_n.status = (tp == in_q.source_port) ? ST_SAME_PORT : ST_OK;
          end
        end
        REQ_BROADCAST: begin
          job_n.fan  = FAN_BCAST;
          job_n.kind = KIND_BCAST;
          job_n.dest = in_q.dest_node;
          job_n.data = in_q.data;
        end
        REQ_BARRIER: begin
          if (32'(in_q.source_node) >= NODES) begin
            job_n.status = ST_UNKNOWN;
          end else if (bflags[sn_i]) begin
            job_n.status = ST_DUP_BARRIER;
          end else if (32'(bcount_inc) == NODES) begin
            job_n.fan   = FAN_ALL;
            job_n.kind  = KIND_RELEASE;
            bflags_next = '0;
            bcount_next = '0;
          end else begin
            quiet             = 1'b1;
            bflags_next[sn_i] = 1'b1;
            bcount_next       = bcount_inc;
          end
        end
        REQ_REDUCE: begin
          if (any && rflags[sp_i]) begin
            job_n.status = ST_DUP_REDUCE;
          end else if (any && (in_q.op_type != rop)) begin
            job_n.status = ST_OP_MISMATCH;
          end else if (32'(rcount_inc) == PORTS - 1) begin
            if (32'(tp2) >= PORTS) begin
              job_n.status = ST_UNKNOWN;
            end else if (nf[tp2[RFW-1:0]]) begin
              job_n.status = ST_TARGET_SRC;
            end else begin
              job_n.port  = tp2;
              job_n.kind  = KIND_REDUCE;
              job_n.dest  = nd;
              job_n.op    = no;
              job_n.data  = nv;
              rflags_next = '0;
              rcount_next = '0;
              rdest_next  = nd;
              rop_next    = no;
              rval_next   = nv;
            end
          end else begin
            quiet       = 1'b1;
            rflags_next = nf;
            rcount_next = rcount_inc;
            rdest_next  = nd;
            rop_next    = no;
            rval_next   = nv;
          end
        end
        default: begin
          job_n.status = ST_UNKNOWN;
        end
      endcase
    end
  end

  assign proceed   = in_valid && (quiet || job_ready);
  assign job_load  = proceed && !quiet;
  assign msg_stall = in_valid && !proceed;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      bflags   <= '0;
      bcount   <= '0;
      rflags   <= '0;
      rcount   <= '0;
      rdest    <= '0;
      rop      <= '0;
      rval     <= '0;
    end else begin
      if (!msg_stall) begin
        in_valid <= msg_valid;
      end
      if (proceed) begin
        bflags <= bflags_next;
        bcount <= bcount_next;
        rflags <= rflags_next;
        rcount <= rcount_next;
        rdest  <= rdest_next;
        rop    <= rop_next;
        rval   <= rval_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!msg_stall && msg_valid) begin
      in_q <= msg;
    end
  end

  `CSR_ASSERT_IMP(a_bcount_match, 1'b1, 32'(bcount) == $countones(bflags), "barrier count off")
  `CSR_ASSERT_IMP(a_rcount_match, 1'b1, 32'(rcount) == $countones(rflags), "reduce count off")
  `CSR_ASSERT_IMP(a_rcount_open, 1'b1, 32'(rcount) < PORTS - 1, "reduce left complete")
  `CSR_ASSERT_NEXT(a_fatal_keeps, proceed && (job_n.status > ST_SAME_PORT),
                   $stable(rflags) && $stable(rval), "fatal error changed state")

endmodule

`default_nettype wire

### src/csr_fanout.sv
// job register and output register: sends one result item per cycle while res_stall is low
// depends on csr_pkg and the assertion macro header
`default_nettype none

`include "core_switch_collective_router_unit_defines.svh"

module csr_fanout import csr_pkg::*; #(
  parameter int PORTS = PORTS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic job_load,
  input  wire job_t job_n,
  output logic      job_ready,
  output logic      res_valid,
  input  wire logic res_stall,
  output res_t      res
);

  localparam int IW = ($clog2(PORTS) > PORT_W) ? $clog2(PORTS) : PORT_W;

  logic          job_valid;
  job_t          job;
  logic [IW-1:0] idx;
  logic [IW:0]   nxt1, nxt;
  logic          out_free, emit, last;
  res_t          cur;

  assign nxt1     = (IW+1)'(idx) + (IW+1)'(1);
  assign nxt      = ((job.fan == FAN_BCAST) && (nxt1 == (IW+1)'(job.sp))) ?
                    nxt1 + (IW+1)'(1) : nxt1;
  assign last     = (job.fan == FAN_ONE) || (32'(nxt) >= PORTS);
  assign out_free = !res_valid || !res_stall;
  assign emit     = job_valid && out_free;
  assign job_ready = !job_valid || (emit && last);

  always_comb begin
    cur          = '0;
    cur.out_kind = job.kind;
    cur.out_dest = job.dest;
    cur.out_op   = job.op;
    cur.out_data = job.data;
    cur.status   = job.status;
    cur.last     = last;
    case (job.fan)
      FAN_ONE:   cur.out_port = job.port;
      FAN_BCAST: cur.out_port = idx[PORT_W-1:0];
      FAN_ALL:   cur.out_port = idx[PORT_W-1:0];
      default:   cur.out_port = job.port;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (job_load) begin
        job_valid <= 1'b1;
      end else if (emit && last) begin
        job_valid <= 1'b0;
      end
      if (emit) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_load) begin
      job <= job_n;
      idx <= ((job_n.fan == FAN_BCAST) && (job_n.sp == '0)) ? IW'(1) : '0;
    end else if (emit && !last) begin
      idx <= nxt[IW-1:0];
    end
    if (emit) begin
      res <= cur;
    end
  end

  `CSR_ASSERT_IMP(a_idx_range, job_valid, 32'(idx) < PORTS, "port counter out of range")
  `CSR_ASSERT_IMP(a_bcast_skip, job_valid && (job.fan == FAN_BCAST),
                  idx != IW'(job.sp), "broadcast copy to its own port")
  `CSR_ASSERT_IMP(a_one_idle, job_valid && (job.fan == FAN_ONE), idx == '0,
                  "single result with counter moved")

endmodule

`default_nettype wire

### src/core_switch_collective_router_unit.sv
// Collective router switch core: unicast, broadcast, barrier and reduce.
// Channels: msg (msg_valid, msg_stall, msg) carries one arriving message per item;
// res (res_valid, res_stall, res) carries the resulting messages, one per item,
// with last set on the final result that a message causes.
// A message is taken into an input register, decided and folded into the barrier
// and reduce state when it proceeds, its job is loaded into the job register, and
// its first result is then registered in the output register.
// Unicast, reduce results and error results: one message per cycle while res_stall is low.
// Broadcast gives PORTS-1 results, a barrier release PORTS results; the fan-out
// counter sends one result per cycle while res_stall is low, so such a message holds
// the output until its last result. Barrier arrivals that do not release and reduce
// arrivals that do not complete give no result and do not wait for the output.
// Reset clears barrier flags, reduce flags, the reduce accumulator and all valids.
// When res_stall is high the output register holds; the job and input registers
// behind it fill and then msg_stall rises. Both stalls are combinational.
// depends on csr_pkg, csr_engine and csr_fanout
`default_nettype none

module core_switch_collective_router_unit import csr_pkg::*; #(
  parameter int PORTS = PORTS_DEF,
  parameter int NODES = NODES_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic msg_valid,
  output logic      msg_stall,
  input  wire msg_t msg,
  output logic      res_valid,
  input  wire logic res_stall,
  output res_t      res
);

  logic job_ready;
  logic job_load;
  job_t job_n;

  csr_engine #(
    .PORTS(PORTS),
    .NODES(NODES)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg_valid),
    .msg_stall (msg_stall),
    .msg       (msg),
    .job_ready (job_ready),
    .job_load  (job_load),
    .job_n     (job_n)
  );

  csr_fanout #(
    .PORTS(PORTS)
  ) u_fanout (
    .clk       (clk),
    .rst       (rst),
    .job_load  (job_load),
    .job_n     (job_n),
    .job_ready (job_ready),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

`default_nettype wire

### bench/tb_top.sv
// testbench for core_switch_collective_router_unit: routing, barrier and reduce
// random and directed messages checked against an in-bench predictor of the switch
// depends on csr_pkg and the router rtl
`timescale 1ns / 1ps

module tb_top;
  import csr_pkg::*;

  localparam logic [TYPE_W-1:0] REQ_UNKNOWN_LO = 3'd4;
  localparam logic [TYPE_W-1:0] REQ_UNKNOWN_HI = 3'd7;
  localparam int RANDOM_MSGS    = 500;
  localparam int MAX_WAIT       = 10;
  localparam int LONG_HOLD      = 300;
  localparam int DRAIN_CYCLES   = 20;
  localparam int TIMEOUT_CYCLES = 200000;

  class switch_scoreboard;
    res_t                 pending_results[$];
    logic [NODES_DEF-1:0] barrier_set;
    logic [PORTS_DEF-1:0] reduce_set;
    logic [NODE_W-1:0]    red_dest;
    logic [OP_W-1:0]      red_op;
    logic [DATA_W-1:0]    red_acc;
    int                   mismatches;
    int                   checked;
    int                   seen_kind[8];

    function new();
      barrier_set = '0;
      reduce_set  = '0;
      red_dest    = '0;
      red_op      = '0;
      red_acc     = '0;
      mismatches  = 0;
      checked     = 0;
      foreach (seen_kind[i]) seen_kind[i] = 0;
    endfunction

    function res_t make_result(logic [PORT_W-1:0] port, logic [KIND_W-1:0] kind,
                               logic [NODE_W-1:0] dest, logic [OP_W-1:0] op,
                               logic [DATA_W-1:0] data, logic [STAT_W-1:0] st);
      res_t r;
      r.out_port = port;
      r.out_kind = kind;
      r.out_dest = dest;
      r.out_op   = op;
      r.out_data = data;
      r.status   = st;
      r.last     = 1'b0;
      return r;
    endfunction

    function void reject(logic [STAT_W-1:0] st);
      res_t r;
      r = make_result('0, KIND_NONE, '0, '0, '0, st);
      r.last = 1'b1;
      pending_results.push_back(r);
    endfunction

    function logic [DATA_W-1:0] fold(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] a,
                                     logic signed [DATA_W-1:0] b);
      case (op)
        OP_MAX:  return (a < b) ? b : a;
        OP_MIN:  return (b < a) ? b : a;
        OP_SUM:  return a + b;
        default: return a * b;
      endcase
    endfunction

    // works out the messages that one accepted item sends and updates the state
    function void route_msg(msg_t m);
      res_t                 batch[$];
      int                   tp;
      logic [PORTS_DEF-1:0] nf;
      logic [NODE_W-1:0]    nd;
      logic [OP_W-1:0]      no;
      logic [DATA_W-1:0]    nv;
      if (m.req_type > REQ_REDUCE || int'(m.source_port) >= PORTS_DEF) begin
        reject(ST_UNKNOWN);
        return;
      end
      case (m.req_type)
        REQ_UNICAST: begin
          tp = int'(m.dest_node) / NODES_PER_PORT;
          if (tp >= PORTS_DEF) begin
            reject(ST_UNKNOWN);
            return;
          end
          batch.push_back(make_result(PORT_W'(tp), KIND_UNICAST, m.dest_node, '0, m.data,
                                      (tp == m.source_port) ? ST_SAME_PORT : ST_OK));
        end
        REQ_BROADCAST: begin
          for (int p = 0; p < PORTS_DEF; p++)
            if (p != m.source_port)
              batch.push_back(make_result(PORT_W'(p), KIND_BCAST, m.dest_node, '0, m.data,
                                          ST_OK));
        end
        REQ_BARRIER: begin
          if (int'(m.source_node) >= NODES_DEF) begin
            reject(ST_UNKNOWN);
            return;
          end
          if (barrier_set[m.source_node]) begin
            reject(ST_DUP_BARRIER);
            return;
          end
          barrier_set[m.source_node] = 1'b1;
          if (&barrier_set) begin
            for (int p = 0; p < PORTS_DEF; p++)
              batch.push_back(make_result(PORT_W'(p), KIND_RELEASE, '0, '0, '0, ST_OK));
            barrier_set = '0;
          end
        end
        REQ_REDUCE: begin
          nf = reduce_set;
          nd = red_dest;
          no = red_op;
          nv = red_acc;
          if (reduce_set == '0) begin
            nd = m.dest_node;
            no = m.op_type;
            nv = m.data;
          end else begin
            if (reduce_set[m.source_port]) begin
              reject(ST_DUP_REDUCE);
              return;
            end
            if (m.op_type != red_op) begin
              reject(ST_OP_MISMATCH);
              return;
            end
            nv = fold(no, nv, m.data);
          end
          nf[m.source_port] = 1'b1;
          if ($countones(nf) == PORTS_DEF - 1) begin
            tp = int'(nd) / NODES_PER_PORT;
            if (tp >= PORTS_DEF) begin
              reject(ST_UNKNOWN);
              return;
            end
            if (nf[PORT_W'(tp)]) begin
              reject(ST_TARGET_SRC);
              return;
            end
            batch.push_back(make_result(PORT_W'(tp), KIND_REDUCE, nd, no, nv, ST_OK));
            nf = '0;
          end
          reduce_set = nf;
          red_dest   = nd;
          red_op     = no;
          red_acc    = nv;
        end
        default: ;
      endcase
      if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
      foreach (batch[i]) pending_results.push_back(batch[i]);
    endfunction

    function void compare_result(res_t got);
      res_t want;
      checked++;
      if (got.out_kind < 8) seen_kind[got.out_kind]++;
      if (pending_results.size() == 0) begin
        if (mismatches < 10)
          $display("[%0t] result with none expected: port %0d kind %0d data %h status %0d",
                   $time, got.out_port, got.out_kind, got.out_data, got.status);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      if (got.out_port !== want.out_port || got.out_kind !== want.out_kind ||
          got.out_dest !== want.out_dest || got.out_op !== want.out_op ||
          got.out_data !== want.out_data || got.status !== want.status ||
          got.last !== want.last) begin
        if (mismatches < 10) begin
          $display("[%0t] result %0d wrong", $time, checked);
          $display("  expected port %0d kind %0d dest %0d op %0d data %h status %0d last %0d",
                   want.out_port, want.out_kind, want.out_dest, want.out_op,
                   want.out_data, want.status, want.last);
          $display("  actual   port %0d kind %0d dest %0d op %0d data %h status %0d last %0d",
                   got.out_port, got.out_kind, got.out_dest, got.out_op,
                   got.out_data, got.status, got.last);
        end
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic msg_valid;
  logic msg_stall;
  msg_t msg;
  logic res_valid;
  logic res_stall;
  res_t res;
  logic long_hold;

  switch_scoreboard sb;
  int msg_gap_max;
  int res_gap_max;
  int res_wait;
  int sent;

  core_switch_collective_router_unit dut (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg_valid),
    .msg_stall (msg_stall),
    .msg       (msg),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int gap_limit();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 2;
      default: return MAX_WAIT;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] random_data();
    case ($urandom_range(0, 5))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return $urandom_range(0, 8) - 4;
      3:       return $urandom_range(0, 1000);
      default: return $urandom;
    endcase
  endfunction

  // mostly well-formed unicast, broadcast, barrier and reduce traffic plus unknown
  // types, kept clear of reduce states that could never complete again
  function automatic msg_t random_msg();
    msg_t            m;
    int              pick;
    int              tp;
    int              sel;
    logic [OP_W-1:0] delta;
    m.req_type    = REQ_UNICAST;
    m.source_port = PORT_W'($urandom);
    m.dest_node   = NODE_W'($urandom);
    m.source_node = NODE_W'($urandom);
    m.op_type     = OP_W'($urandom);
    m.data        = random_data();
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      m.req_type = TYPE_W'($urandom_range(REQ_UNKNOWN_LO, REQ_UNKNOWN_HI));
    end else if (pick < 25) begin
      m.req_type = REQ_UNICAST;
    end else if (pick < 40) begin
      m.req_type = REQ_BROADCAST;
    end else if (pick < 65) begin
      m.req_type = REQ_BARRIER;
      if ($urandom_range(0, 6) == 0 && sb.barrier_set != '0) begin
        do m.source_node = NODE_W'($urandom); while (!sb.barrier_set[m.source_node]);
      end else begin
        do m.source_node = NODE_W'($urandom); while (sb.barrier_set[m.source_node]);
      end
    end else begin
      m.req_type = REQ_REDUCE;
      if (sb.reduce_set == '0) begin
        tp = int'(m.dest_node) / NODES_PER_PORT;
        do m.source_port = PORT_W'($urandom); while (m.source_port == tp);
      end else begin
        tp = int'(sb.red_dest) / NODES_PER_PORT;
        sel = $urandom_range(0, 9);
        m.op_type = sb.red_op;
        if (sel == 2 && $countones(sb.reduce_set) == PORTS_DEF - 2) begin
          m.source_port = PORT_W'(tp);
        end else if (sel == 0) begin
          do m.source_port = PORT_W'($urandom); while (!sb.reduce_set[m.source_port]);
        end else if (sel == 1) begin
          delta = OP_W'($urandom_range(1, 3));
          m.op_type = sb.red_op + delta;
        end else begin
          do m.source_port = PORT_W'($urandom);
          while (sb.reduce_set[m.source_port] || m.source_port == tp);
        end
      end
    end
    return m;
  endfunction

  task automatic send_msg(input msg_t m);
    int gap;
    gap = $urandom_range(0, msg_gap_max);
    if (gap > 0) begin
      msg_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    msg       <= m;
    msg_valid <= 1'b1;
    @(posedge clk);
    while (msg_stall) @(posedge clk);
    sb.route_msg(m);
    sent++;
  endtask

  task automatic send_req(input logic [TYPE_W-1:0] t, input logic [PORT_W-1:0] sp,
                          input logic [NODE_W-1:0] dn, input logic [NODE_W-1:0] sn,
                          input logic [OP_W-1:0] op, input logic [DATA_W-1:0] d);
    msg_t m;
    m.req_type    = t;
    m.source_port = sp;
    m.dest_node   = dn;
    m.source_node = sn;
    m.op_type     = op;
    m.data        = d;
    send_msg(m);
  endtask

  task automatic hold_results();
    long_hold <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    long_hold <= 1'b0;
  endtask

  task automatic wait_drained();
    msg_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  // result side
  initial begin
    res_stall   = 1'b0;
    res_wait    = 0;
    res_gap_max = MAX_WAIT;
    forever begin
      @(posedge clk);
      if (res_valid && !res_stall) begin
        sb.compare_result(res);
        if (sb.checked % 40 == 0) res_gap_max = gap_limit();
        res_wait = $urandom_range(0, res_gap_max);
      end else if (res_wait > 0) begin
        res_wait--;
      end
      res_stall <= long_hold || (res_wait > 0);
    end
  end

  initial begin
    sb          = new();
    rst         = 1'b1;
    msg_valid   = 1'b0;
    msg         = '0;
    long_hold   = 1'b0;
    msg_gap_max = MAX_WAIT;
    sent        = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // unicast to own port and far port, broadcasts, unknown types
    send_req(REQ_UNICAST, 2'd0, 4'd0, 4'd0, OP_MAX, 32'sh7FFF_FFFF);
    send_req(REQ_UNICAST, 2'd1, 4'd15, 4'd15, OP_MUL, 32'sh8000_0000);
    send_req(REQ_BROADCAST, 2'd0, 4'd0, 4'd0, OP_MAX, 32'h0);
    send_req(REQ_BROADCAST, 2'd3, 4'd15, 4'd15, OP_MUL, 32'hFFFF_FFFF);
    send_req(REQ_UNKNOWN_LO, 2'd2, 4'd5, 4'd5, OP_SUM, 32'd1);
    send_req(REQ_UNKNOWN_HI, 2'd3, 4'd15, 4'd15, OP_MUL, 32'hFFFF_FFFF);
    // barrier arrival then duplicate
    send_req(REQ_BARRIER, 2'd0, 4'd0, 4'd15, OP_MAX, 32'h0);
    send_req(REQ_BARRIER, 2'd2, 4'd0, 4'd15, OP_MAX, 32'h0);
    // max toward node 0 with duplicate, op mismatch and target-port errors
    send_req(REQ_REDUCE, 2'd1, 4'd0, 4'd0, OP_MAX, 32'sh8000_0000);
    send_req(REQ_REDUCE, 2'd1, 4'd0, 4'd0, OP_MAX, 32'd5);
    send_req(REQ_REDUCE, 2'd2, 4'd0, 4'd0, OP_MIN, 32'd5);
    send_req(REQ_REDUCE, 2'd2, 4'd3, 4'd0, OP_MAX, -32'sd7);
    send_req(REQ_REDUCE, 2'd0, 4'd0, 4'd0, OP_MAX, 32'd9);
    send_req(REQ_REDUCE, 2'd3, 4'd0, 4'd0, OP_MAX, 32'sh7FFF_FFFF);
    // min, wrapping sum and wrapping product
    send_req(REQ_REDUCE, 2'd0, 4'd15, 4'd0, OP_MIN, 32'sh7FFF_FFFF);
    send_req(REQ_REDUCE, 2'd1, 4'd15, 4'd0, OP_MIN, 32'sh8000_0000);
    send_req(REQ_REDUCE, 2'd2, 4'd15, 4'd0, OP_MIN, 32'h0);
    send_req(REQ_REDUCE, 2'd0, 4'd4, 4'd0, OP_SUM, 32'sh7FFF_FFFF);
    send_req(REQ_REDUCE, 2'd2, 4'd4, 4'd0, OP_SUM, 32'd1);
    send_req(REQ_REDUCE, 2'd3, 4'd4, 4'd0, OP_SUM, 32'd5);
    send_req(REQ_REDUCE, 2'd0, 4'd8, 4'd0, OP_MUL, 32'h0001_0000);
    send_req(REQ_REDUCE, 2'd1, 4'd8, 4'd0, OP_MUL, 32'h0001_0000);
    send_req(REQ_REDUCE, 2'd3, 4'd8, 4'd0, OP_MUL, 32'd3);

    for (int n = 0; n < RANDOM_MSGS; n++) begin
      if (n % 50 == 0) msg_gap_max = gap_limit();
      if (n == 150) begin
        msg_gap_max = 0;
        fork
          hold_results();
        join_none
      end
      if (n == 300) wait_drained();
      send_msg(random_msg());
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d messages sent, %0d results checked, %0d mismatches", sent, sb.checked,
             sb.mismatches);
    $display("results: %0d unicast, %0d broadcast copies, %0d releases, %0d reduce",
             sb.seen_kind[KIND_UNICAST], sb.seen_kind[KIND_BCAST], sb.seen_kind[KIND_RELEASE],
             sb.seen_kind[KIND_REDUCE]);
    $display("  and %0d status only", sb.seen_kind[KIND_NONE]);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    repeat (TIMEOUT_CYCLES) @(posedge clk);
    $display("timeout with %0d results outstanding", sb.pending_results.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
